>>> sv/c8x_pkg.sv
`timescale 1ns / 1ps
// c8x_pkg: types and constants shared by the instruction execute core.
// No dependencies; every other file but c8x_ram uses it.
package c8x_pkg;

    localparam int MEM_DEPTH  = 4096;
    localparam int MEM_AW     = 12;
    localparam int SCR_W      = 128;
    localparam int SCR_H      = 64;
    localparam int SCR_RAW    = 6;
    localparam int SCR_CAW    = 7;
    localparam int FLAG_SLOTS = 8;
    localparam int FLAG_AW    = 3;
    localparam int CFG_W      = 12;

    localparam logic [1:0] KIND_EXEC  = 2'd0;
    localparam logic [1:0] KIND_WRMEM = 2'd1;
    localparam logic [1:0] KIND_RDMEM = 2'd2;
    localparam logic [1:0] KIND_RDPIX = 2'd3;

    localparam logic [1:0] CFG_QUIRK      = 2'd0;
    localparam logic [1:0] CFG_SMALL_FONT = 2'd1;
    localparam logic [1:0] CFG_LARGE_FONT = 2'd2;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_DIGIT     = 2'd1;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd2;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd3;

    localparam logic [11:0] PC_RESET         = 12'h200;
    localparam logic [11:0] SMALL_FONT_RESET = 12'd80;
    localparam logic [11:0] LARGE_FONT_RESET = 12'd160;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [15:0] opcode;
        logic [7:0]  random_byte;
        logic [15:0] keys_down;
        logic [12:0] access_address;
        logic [7:0]  write_byte;
    } cmd_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] index_value;
        logic [7:0]  read_data;
        logic        draw_requested;
        logic        exit_requested;
        logic        high_res;
        logic        waiting_key;
        logic [1:0]  fault_code;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
    } rsp_t;

    typedef struct packed {
        logic        quirk_mode;
        logic [11:0] small_font_base;
        logic [11:0] large_font_base;
    } cfg_t;

    typedef enum logic [5:0] {
        CL_NOP, CL_WRMEM, CL_RDMEM, CL_RDPIX,
        CL_SCRD, CL_CLS, CL_RET, CL_SCRR, CL_SCRL, CL_EXIT, CL_LORES, CL_HIRES,
        CL_JP, CL_CALL, CL_SE_K, CL_SNE_K, CL_SE_V, CL_SNE_V, CL_LD_K, CL_ADD_K,
        CL_ALU, CL_LD_I, CL_JPV, CL_RND, CL_DRW, CL_SKP, CL_SKNP,
        CL_GET_DT, CL_WKEY, CL_SET_DT, CL_SET_ST, CL_ADD_I, CL_FONT, CL_BFONT,
        CL_BCD, CL_STORE, CL_LOAD, CL_FSAVE, CL_FLOAD
    } op_class_t;

    typedef struct packed {
        op_class_t cls;
        cmd_t      cmd;
    } qent_t;

    typedef struct packed {
        logic clearing;
        logic res_load;
    } status_t;

endpackage

>>> sv/c8x_ram.sv
`timescale 1ns / 1ps
// c8x_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module c8x_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/c8x_front.sv
`timescale 1ns / 1ps
// c8x_front: accepts requests, classifies the opcode and queues them (2 deep).
// Depends on c8x_pkg.
module c8x_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  c8x_pkg::cmd_t    cmd,
    input  logic             hold,
    output c8x_pkg::qent_t   head,
    output logic             head_valid,
    input  logic             head_pop
);

    localparam logic [15:0] OP_CLS   = 16'h00E0;
    localparam logic [15:0] OP_RET   = 16'h00EE;
    localparam logic [15:0] OP_SCRR  = 16'h00FB;
    localparam logic [15:0] OP_SCRL  = 16'h00FC;
    localparam logic [15:0] OP_EXIT  = 16'h00FD;
    localparam logic [15:0] OP_LORES = 16'h00FE;
    localparam logic [15:0] OP_HIRES = 16'h00FF;
    localparam logic [11:0] OP_SCRD  = 12'h00C;

    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_WKEY   = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BFONT  = 8'h30;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;
    localparam logic [7:0] FX_FSAVE  = 8'h75;
    localparam logic [7:0] FX_FLOAD  = 8'h85;
    localparam logic [7:0] EX_SKP    = 8'h9E;
    localparam logic [7:0] EX_SKNP   = 8'hA1;

    function automatic c8x_pkg::op_class_t classify(input c8x_pkg::cmd_t c);
        logic [15:0] op;
        c8x_pkg::op_class_t cls;
        op  = c.opcode;
        cls = c8x_pkg::CL_NOP;
        unique case (c.item_kind)
            c8x_pkg::KIND_WRMEM: cls = c8x_pkg::CL_WRMEM;
            c8x_pkg::KIND_RDMEM: cls = c8x_pkg::CL_RDMEM;
            c8x_pkg::KIND_RDPIX: cls = c8x_pkg::CL_RDPIX;
            c8x_pkg::KIND_EXEC:
            begin
                unique case (op[15:12])
                    4'h0:
                    begin
                        if (op[15:4] == OP_SCRD)   cls = c8x_pkg::CL_SCRD;
                        else if (op == OP_CLS)     cls = c8x_pkg::CL_CLS;
                        else if (op == OP_RET)     cls = c8x_pkg::CL_RET;
                        else if (op == OP_SCRR)    cls = c8x_pkg::CL_SCRR;
                        else if (op == OP_SCRL)    cls = c8x_pkg::CL_SCRL;
                        else if (op == OP_EXIT)    cls = c8x_pkg::CL_EXIT;
                        else if (op == OP_LORES)   cls = c8x_pkg::CL_LORES;
                        else if (op == OP_HIRES)   cls = c8x_pkg::CL_HIRES;
                    end
                    4'h1: cls = c8x_pkg::CL_JP;
                    4'h2: cls = c8x_pkg::CL_CALL;
                    4'h3: cls = c8x_pkg::CL_SE_K;
                    4'h4: cls = c8x_pkg::CL_SNE_K;
                    4'h5: if (op[3:0] == 4'h0) cls = c8x_pkg::CL_SE_V;
                    4'h6: cls = c8x_pkg::CL_LD_K;
                    4'h7: cls = c8x_pkg::CL_ADD_K;
                    4'h8: if (op[3:0] <= 4'h7 || op[3:0] == 4'hE) cls = c8x_pkg::CL_ALU;
                    4'h9: if (op[3:0] == 4'h0) cls = c8x_pkg::CL_SNE_V;
                    4'hA: cls = c8x_pkg::CL_LD_I;
                    4'hB: cls = c8x_pkg::CL_JPV;
                    4'hC: cls = c8x_pkg::CL_RND;
                    4'hD: cls = c8x_pkg::CL_DRW;
                    4'hE:
                    begin
                        if (op[7:0] == EX_SKP)       cls = c8x_pkg::CL_SKP;
                        else if (op[7:0] == EX_SKNP) cls = c8x_pkg::CL_SKNP;
                    end
                    4'hF:
                    begin
                        unique case (op[7:0])
                            FX_GET_DT: cls = c8x_pkg::CL_GET_DT;
                            FX_WKEY:   cls = c8x_pkg::CL_WKEY;
                            FX_SET_DT: cls = c8x_pkg::CL_SET_DT;
                            FX_SET_ST: cls = c8x_pkg::CL_SET_ST;
                            FX_ADD_I:  cls = c8x_pkg::CL_ADD_I;
                            FX_FONT:   cls = c8x_pkg::CL_FONT;
                            FX_BFONT:  cls = c8x_pkg::CL_BFONT;
                            FX_BCD:    cls = c8x_pkg::CL_BCD;
                            FX_STORE:  cls = c8x_pkg::CL_STORE;
                            FX_LOAD:   cls = c8x_pkg::CL_LOAD;
                            FX_FSAVE:  cls = c8x_pkg::CL_FSAVE;
                            FX_FLOAD:  cls = c8x_pkg::CL_FLOAD;
                            default:   cls = c8x_pkg::CL_NOP;
                        endcase
                    end
                    default: cls = c8x_pkg::CL_NOP;
                endcase
            end
            default: cls = c8x_pkg::CL_NOP;
        endcase
        return cls;
    endfunction

    c8x_pkg::qent_t ent_reg [2];
    logic           rd_ptr_reg, rd_ptr_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == 2'd2) || hold;
    assign do_push    = push && !full;
    assign head_valid = (count_reg != 2'd0);
    assign do_pop     = head_pop && head_valid;
    assign head       = ent_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= '{cls: classify(cmd), cmd: cmd};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/c8x_back.sv
`timescale 1ns / 1ps
// c8x_back: execution sequencer; holds registers, stack, memory and screen.
// Depends on c8x_pkg and c8x_ram.
module c8x_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  c8x_pkg::cfg_t    cfg,
    input  c8x_pkg::qent_t   head,
    input  logic             head_valid,
    output logic             head_pop,
    input  logic             out_free,
    output c8x_pkg::rsp_t    res,
    output c8x_pkg::status_t st
);

    localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int SW     = c8x_pkg::SCR_W;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;
    localparam logic [3:0] VF      = 4'hF;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_RX, S_RY, S_EXEC, S_WX, S_MEMRD, S_PIXRD, S_RET,
        S_SCR_RD, S_SCR_WR, S_D_RD, S_D_WR, S_D_VF, S_BCD1, S_BCD2,
        S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_FS_RD, S_FS_WR, S_FL, S_DONE
    } state_t;

    // hundreds, tens, ones of a byte; tens through the 205/2048 reciprocal
    function automatic logic [11:0] bcd(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : (v >= 8'd100) ? 2'd1 : 2'd0;
        rem  = (v >= 8'd200) ? 7'(v - 8'd200) : (v >= 8'd100) ? 7'(v - 8'd100) : v[6:0];
        prod = 15'(rem) * 15'd205;
        t    = prod[14:11];
        o    = rem - 7'(t * 4'd10);
        return {2'b00, h, t, o[3:0]};
    endfunction

    state_t                state_reg, state_next;
    c8x_pkg::qent_t        item_reg, item_next;
    logic [7:0]            vx_reg, vx_next, vy_reg, vy_next;
    logic [11:0]           pc_reg, pc_next;
    logic [15:0]           i_reg, i_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [7:0]            dt_reg, dt_next, snd_reg, snd_next;
    logic                  hires_reg, hires_next, exit_reg, exit_next;
    logic [6:0]            cnt_reg, cnt_next;
    logic [7:0]            res_reg, res_next;
    logic [3:0]            bcd1_reg, bcd1_next, bcd2_reg, bcd2_next;
    logic                  hit_reg, hit_next;
    logic [7:0]            rd_reg, rd_next;
    logic                  draw_reg, draw_next, wait_reg, wait_next;
    logic [1:0]            fault_reg, fault_next;
    logic [15:0]           vvalid_reg, vvalid_next;
    logic                  vrvalid_reg;
    logic [7:0]            flag_reg [c8x_pkg::FLAG_SLOTS];
    logic                  flag_we;
    logic                  clr_op_reg, clr_op_next;

    logic                  v_we;
    logic [3:0]            v_waddr, v_raddr;
    logic [7:0]            v_wdata, v_rdata, v_data;
    logic                  m_we;
    logic [c8x_pkg::MEM_AW-1:0] m_waddr, m_raddr;
    logic [7:0]            m_wdata, m_rdata;
    logic                  s_we;
    logic [c8x_pkg::SCR_RAW-1:0] s_waddr, s_raddr;
    logic [SW-1:0]         s_wdata, s_rdata;
    logic                  k_we;
    logic [STK_AW-1:0]     k_waddr, k_raddr;
    logic [11:0]           k_wdata, k_rdata;

    logic [15:0]           op;
    logic [3:0]            x, y, n;
    logic [7:0]            kk;
    logic [11:0]           nnn, pc_adv, pc_skip;
    logic [15:0]           i_plus;
    logic [8:0]            alu_wide;
    logic [7:0]            shift_src;
    logic [11:0]           digits;
    logic [6:0]            cx, y_pos;
    logic [5:0]            cy;
    logic [6:0]            rows;
    logic                  row_ok;
    logic [c8x_pkg::SCR_RAW-1:0] phys_row, scr_row;
    logic [7:0]            rev;
    logic [SW-1:0]         spr_base, spr_line;
    logic [3:0]            key_idx;
    logic                  key_any;
    logic                  last_r;

    c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(c8x_pkg::MEM_DEPTH)) u_mem (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    c8x_ram #(.WIDTH(SW), .DEPTH(c8x_pkg::SCR_H)) u_screen (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    // registers never written read as zero
    assign v_data = v_rdata & {8{vrvalid_reg}};

    assign op      = item_reg.cmd.opcode;
    assign x       = op[11:8];
    assign y       = op[7:4];
    assign n       = op[3:0];
    assign kk      = op[7:0];
    assign nnn     = op[11:0];
    assign pc_adv  = pc_reg + 12'd2;
    assign pc_skip = pc_reg + 12'd4;
    assign i_plus  = i_reg + {9'd0, cnt_reg};
    assign digits  = bcd(vx_reg);
    assign last_r  = (cnt_reg == {3'd0, x});

    // sprite row geometry; low-res row y sits in half (y & 1) of screen row y/2
    assign cx       = hires_reg ? vx_reg[6:0] : {1'b0, vx_reg[5:0]};
    assign cy       = hires_reg ? vy_reg[5:0] : {1'b0, vy_reg[4:0]};
    assign y_pos    = {1'b0, cy} + cnt_reg;
    assign rows     = (n == 4'd0) ? 7'd16 : {3'd0, n};
    assign row_ok   = (cnt_reg < rows) &&
                      (hires_reg ? (y_pos < 7'(c8x_pkg::SCR_H)) : (y_pos < 7'(c8x_pkg::SCR_H / 2)));
    assign phys_row = hires_reg ? y_pos[5:0] : {1'b0, y_pos[5:1]};
    assign scr_row  = cnt_reg[5:0];

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            rev[b] = m_rdata[7 - b];
        end
        spr_base = SW'(rev) << cx;
        if (hires_reg)
        begin
            spr_line = spr_base;
        end
        else
        begin
            spr_line = (spr_base & {{(SW / 2){1'b0}}, {(SW / 2){1'b1}}})
                       << (y_pos[0] ? (SW / 2) : 0);
        end
    end

    always_comb
    begin
        key_idx = 4'd0;
        key_any = 1'b0;
        for (int k = 15; k >= 0; k--)
        begin
            if (item_reg.cmd.keys_down[k])
            begin
                key_idx = 4'(k);
                key_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (n)
            ALU_ADD: alu_wide = {1'b0, vx_reg} + {1'b0, vy_reg};
            ALU_SUB: alu_wide = {1'b0, vx_reg} - {1'b0, vy_reg};
            ALU_RSB: alu_wide = {1'b0, vy_reg} - {1'b0, vx_reg};
            default: alu_wide = 9'd0;
        endcase
        shift_src = cfg.quirk_mode ? vx_reg : vy_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        pc_next     = pc_reg;
        i_next      = i_reg;
        lvl_next    = lvl_reg;
        dt_next     = dt_reg;
        snd_next    = snd_reg;
        hires_next  = hires_reg;
        exit_next   = exit_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        bcd1_next   = bcd1_reg;
        bcd2_next   = bcd2_reg;
        hit_next    = hit_reg;
        rd_next     = rd_reg;
        draw_next   = draw_reg;
        wait_next   = wait_reg;
        fault_next  = fault_reg;
        clr_op_next = clr_op_reg;
        head_pop    = 1'b0;
        flag_we     = 1'b0;
        st.res_load = 1'b0;
        st.clearing = (state_reg == S_CLR) && !clr_op_reg;

        v_we    = 1'b0;
        v_waddr = x;
        v_wdata = res_reg;
        v_raddr = y;
        m_we    = 1'b0;
        m_waddr = i_plus[c8x_pkg::MEM_AW-1:0];
        m_wdata = v_data;
        m_raddr = i_plus[c8x_pkg::MEM_AW-1:0];
        s_we    = 1'b0;
        s_waddr = scr_row;
        s_wdata = '0;
        s_raddr = scr_row;
        k_we    = 1'b0;
        k_waddr = lvl_reg[STK_AW-1:0];
        k_wdata = pc_adv;
        k_raddr = STK_AW'(lvl_reg - LVL_W'(1));

        unique case (state_reg)
            S_CLR:
            begin
                s_we    = 1'b1;
                s_wdata = '0;
                if (cnt_reg == 7'(c8x_pkg::SCR_H - 1))
                begin
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
                cnt_next = cnt_reg + 7'd1;
            end

            S_IDLE:
            begin
                if (head_valid)
                begin
                    head_pop   = 1'b1;
                    item_next  = head;
                    // jump with offset reads V0 unless the SUPER-CHIP quirk is set
                    v_raddr    = (head.cls == c8x_pkg::CL_JPV && !cfg.quirk_mode) ?
                                 4'd0 : head.cmd.opcode[11:8];
                    rd_next    = 8'd0;
                    draw_next  = 1'b0;
                    wait_next  = 1'b0;
                    fault_next = c8x_pkg::FAULT_NONE;
                    state_next = S_RX;
                end
            end

            S_RX:
            begin
                vx_next    = v_data;
                v_raddr    = y;
                state_next = S_RY;
            end

            S_RY:
            begin
                vy_next    = v_data;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                if (item_reg.cmd.item_kind == c8x_pkg::KIND_EXEC)
                begin
                    pc_next = pc_adv;
                end
                unique case (item_reg.cls)
                    c8x_pkg::CL_WRMEM:
                    begin
                        m_we    = 1'b1;
                        m_waddr = item_reg.cmd.access_address[c8x_pkg::MEM_AW-1:0];
                        m_wdata = item_reg.cmd.write_byte;
                    end
                    c8x_pkg::CL_RDMEM:
                    begin
                        m_raddr    = item_reg.cmd.access_address[c8x_pkg::MEM_AW-1:0];
                        state_next = S_MEMRD;
                    end
                    c8x_pkg::CL_RDPIX:
                    begin
                        // 13-bit index never passes the 8192-pixel array
                        s_raddr    = item_reg.cmd.access_address[12:c8x_pkg::SCR_CAW];
                        state_next = S_PIXRD;
                    end
                    c8x_pkg::CL_SCRD, c8x_pkg::CL_SCRR, c8x_pkg::CL_SCRL:
                    begin
                        cnt_next   = 7'(c8x_pkg::SCR_H - 1);
                        state_next = S_SCR_RD;
                    end
                    c8x_pkg::CL_CLS:
                    begin
                        draw_next   = 1'b1;
                        cnt_next    = 7'd0;
                        clr_op_next = 1'b1;
                        state_next  = S_CLR;
                    end
                    c8x_pkg::CL_RET:
                    begin
                        if (lvl_reg == '0)
                        begin
                            fault_next = c8x_pkg::FAULT_UNDERFLOW;
                        end
                        else
                        begin
                            lvl_next   = lvl_reg - LVL_W'(1);
                            state_next = S_RET;
                        end
                    end
                    c8x_pkg::CL_EXIT:  exit_next  = 1'b1;
                    c8x_pkg::CL_LORES: hires_next = 1'b0;
                    c8x_pkg::CL_HIRES: hires_next = 1'b1;
                    c8x_pkg::CL_JP:    pc_next    = nnn;
                    c8x_pkg::CL_CALL:
                    begin
                        if (lvl_reg >= LVL_W'(STACK_DEPTH))
                        begin
                            fault_next = c8x_pkg::FAULT_OVERFLOW;
                        end
                        else
                        begin
                            k_we     = 1'b1;
                            lvl_next = lvl_reg + LVL_W'(1);
                            pc_next  = nnn;
                        end
                    end
                    c8x_pkg::CL_SE_K:  if (vx_reg == kk) pc_next = pc_skip;
                    c8x_pkg::CL_SNE_K: if (vx_reg != kk) pc_next = pc_skip;
                    c8x_pkg::CL_SE_V:  if (vx_reg == vy_reg) pc_next = pc_skip;
                    c8x_pkg::CL_SNE_V: if (vx_reg != vy_reg) pc_next = pc_skip;
                    c8x_pkg::CL_LD_K:
                    begin
                        v_we    = 1'b1;
                        v_wdata = kk;
                    end
                    c8x_pkg::CL_ADD_K:
                    begin
                        v_we    = 1'b1;
                        v_wdata = vx_reg + kk;
                    end
                    c8x_pkg::CL_ALU:
                    begin
                        // flag goes first so a result into VF overrides it
                        case (n)
                            ALU_MOV:
                            begin
                                v_we    = 1'b1;
                                v_wdata = vy_reg;
                            end
                            ALU_OR:
                            begin
                                v_we    = 1'b1;
                                v_wdata = vx_reg | vy_reg;
                            end
                            ALU_AND:
                            begin
                                v_we    = 1'b1;
                                v_wdata = vx_reg & vy_reg;
                            end
                            ALU_XOR:
                            begin
                                v_we    = 1'b1;
                                v_wdata = vx_reg ^ vy_reg;
                            end
                            ALU_ADD:
                            begin
                                v_we       = 1'b1;
                                v_waddr    = VF;
                                v_wdata    = {7'd0, alu_wide[8]};
                                res_next   = alu_wide[7:0];
                                state_next = S_WX;
                            end
                            ALU_SUB, ALU_RSB:
                            begin
                                v_we       = 1'b1;
                                v_waddr    = VF;
                                v_wdata    = {7'd0, !alu_wide[8]};
                                res_next   = alu_wide[7:0];
                                state_next = S_WX;
                            end
                            ALU_SHR:
                            begin
                                v_we       = 1'b1;
                                v_waddr    = VF;
                                v_wdata    = {7'd0, shift_src[0]};
                                res_next   = {1'b0, shift_src[7:1]};
                                state_next = S_WX;
                            end
                            ALU_SHL:
                            begin
                                v_we       = 1'b1;
                                v_waddr    = VF;
                                v_wdata    = {7'd0, shift_src[7]};
                                res_next   = {shift_src[6:0], 1'b0};
                                state_next = S_WX;
                            end
                            default:
                            begin
                                v_we = 1'b0;
                            end
                        endcase
                    end
                    c8x_pkg::CL_LD_I: i_next  = {4'd0, nnn};
                    c8x_pkg::CL_JPV:  pc_next = nnn + {4'd0, vx_reg};
                    c8x_pkg::CL_RND:
                    begin
                        v_we    = 1'b1;
                        v_wdata = item_reg.cmd.random_byte & kk;
                    end
                    c8x_pkg::CL_DRW:
                    begin
                        draw_next  = 1'b1;
                        hit_next   = 1'b0;
                        cnt_next   = 7'd0;
                        state_next = S_D_RD;
                    end
                    c8x_pkg::CL_SKP:
                        if (item_reg.cmd.keys_down[vx_reg[3:0]]) pc_next = pc_skip;
                    c8x_pkg::CL_SKNP:
                        if (!item_reg.cmd.keys_down[vx_reg[3:0]]) pc_next = pc_skip;
                    c8x_pkg::CL_GET_DT:
                    begin
                        v_we    = 1'b1;
                        v_wdata = dt_reg;
                    end
                    c8x_pkg::CL_WKEY:
                    begin
                        if (key_any)
                        begin
                            v_we    = 1'b1;
                            v_wdata = {4'd0, key_idx};
                        end
                        else
                        begin
                            pc_next   = pc_reg;
                            wait_next = 1'b1;
                        end
                    end
                    c8x_pkg::CL_SET_DT: dt_next  = vx_reg;
                    c8x_pkg::CL_SET_ST: snd_next = vx_reg;
                    c8x_pkg::CL_ADD_I:  i_next   = i_reg + {8'd0, vx_reg};
                    c8x_pkg::CL_FONT:
                        i_next = {4'd0, cfg.small_font_base} + 16'(vx_reg[3:0] * 7'd5);
                    c8x_pkg::CL_BFONT:
                    begin
                        if (vx_reg > 8'd9)
                        begin
                            fault_next = c8x_pkg::FAULT_DIGIT;
                        end
                        else
                        begin
                            i_next = {4'd0, cfg.large_font_base} + 16'(vx_reg[3:0] * 7'd10);
                        end
                    end
                    c8x_pkg::CL_BCD:
                    begin
                        m_we       = 1'b1;
                        m_waddr    = i_reg[c8x_pkg::MEM_AW-1:0];
                        m_wdata    = {4'd0, digits[11:8]};
                        bcd1_next  = digits[7:4];
                        bcd2_next  = digits[3:0];
                        state_next = S_BCD1;
                    end
                    c8x_pkg::CL_STORE:
                    begin
                        cnt_next   = 7'd0;
                        state_next = S_ST_RD;
                    end
                    c8x_pkg::CL_LOAD:
                    begin
                        cnt_next   = 7'd0;
                        state_next = S_LD_RD;
                    end
                    c8x_pkg::CL_FSAVE:
                    begin
                        cnt_next   = 7'd0;
                        state_next = S_FS_RD;
                    end
                    c8x_pkg::CL_FLOAD:
                    begin
                        cnt_next   = 7'd0;
                        state_next = S_FL;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_WX:
            begin
                v_we       = 1'b1;
                v_wdata    = res_reg;
                state_next = S_DONE;
            end

            S_MEMRD:
            begin
                rd_next    = m_rdata;
                state_next = S_DONE;
            end

            S_PIXRD:
            begin
                rd_next    = {7'd0, s_rdata[item_reg.cmd.access_address[c8x_pkg::SCR_CAW-1:0]]};
                state_next = S_DONE;
            end

            S_RET:
            begin
                pc_next    = k_rdata;
                state_next = S_DONE;
            end

            S_SCR_RD:
            begin
                // scroll down walks rows bottom-up so sources are read before overwrite
                if (item_reg.cls == c8x_pkg::CL_SCRD)
                begin
                    s_raddr = scr_row - {2'd0, n};
                end
                state_next = S_SCR_WR;
            end

            S_SCR_WR:
            begin
                s_we = 1'b1;
                if (item_reg.cls == c8x_pkg::CL_SCRD)
                begin
                    s_wdata = (scr_row >= {2'd0, n}) ? s_rdata : '0;
                end
                else if (item_reg.cls == c8x_pkg::CL_SCRR)
                begin
                    s_wdata = s_rdata << 4;
                end
                else
                begin
                    s_wdata = s_rdata >> 4;
                end
                cnt_next   = cnt_reg - 7'd1;
                state_next = (cnt_reg == 7'd0) ? S_DONE : S_SCR_RD;
            end

            S_D_RD:
            begin
                m_raddr = i_plus[c8x_pkg::MEM_AW-1:0];
                s_raddr = phys_row;
                state_next = row_ok ? S_D_WR : S_D_VF;
            end

            S_D_WR:
            begin
                s_we       = 1'b1;
                s_waddr    = phys_row;
                s_wdata    = s_rdata ^ spr_line;
                hit_next   = hit_reg | (|(s_rdata & spr_line));
                cnt_next   = cnt_reg + 7'd1;
                state_next = S_D_RD;
            end

            S_D_VF:
            begin
                v_we       = 1'b1;
                v_waddr    = VF;
                v_wdata    = {7'd0, hit_reg};
                state_next = S_DONE;
            end

            S_BCD1:
            begin
                m_we       = 1'b1;
                m_waddr    = 12'(i_reg + 16'd1);
                m_wdata    = {4'd0, bcd1_reg};
                state_next = S_BCD2;
            end

            S_BCD2:
            begin
                m_we       = 1'b1;
                m_waddr    = 12'(i_reg + 16'd2);
                m_wdata    = {4'd0, bcd2_reg};
                state_next = S_DONE;
            end

            S_ST_RD:
            begin
                v_raddr    = cnt_reg[3:0];
                state_next = S_ST_WR;
            end

            S_ST_WR:
            begin
                m_we    = 1'b1;
                m_wdata = v_data;
                if (last_r)
                begin
                    if (!cfg.quirk_mode) i_next = i_reg + {12'd0, x} + 16'd1;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = S_ST_RD;
                end
            end

            S_LD_RD:
            begin
                state_next = S_LD_WR;
            end

            S_LD_WR:
            begin
                v_we    = 1'b1;
                v_waddr = cnt_reg[3:0];
                v_wdata = m_rdata;
                if (last_r)
                begin
                    if (!cfg.quirk_mode) i_next = i_reg + {12'd0, x} + 16'd1;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = S_LD_RD;
                end
            end

            S_FS_RD:
            begin
                v_raddr    = cnt_reg[3:0];
                state_next = S_FS_WR;
            end

            S_FS_WR:
            begin
                flag_we = 1'b1;
                if (last_r || cnt_reg == 7'(c8x_pkg::FLAG_SLOTS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = S_FS_RD;
                end
            end

            S_FL:
            begin
                v_we    = 1'b1;
                v_waddr = cnt_reg[3:0];
                v_wdata = flag_reg[cnt_reg[c8x_pkg::FLAG_AW-1:0]];
                if (last_r || cnt_reg == 7'(c8x_pkg::FLAG_SLOTS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            S_DONE:
            begin
                clr_op_next = 1'b0;
                if (out_free)
                begin
                    st.res_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        vvalid_next = vvalid_reg;
        if (v_we)
        begin
            vvalid_next[v_waddr] = 1'b1;
        end
    end

    assign res.next_pc        = pc_reg;
    assign res.index_value    = i_reg;
    assign res.read_data      = rd_reg;
    assign res.draw_requested = draw_reg;
    assign res.exit_requested = exit_reg;
    assign res.high_res       = hires_reg;
    assign res.waiting_key    = wait_reg;
    assign res.fault_code     = fault_reg;
    assign res.delay_value    = dt_reg;
    assign res.sound_value    = snd_reg;

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        res_reg  <= res_next;
        bcd1_reg <= bcd1_next;
        bcd2_reg <= bcd2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            pc_reg      <= c8x_pkg::PC_RESET;
            i_reg       <= 16'd0;
            lvl_reg     <= '0;
            dt_reg      <= 8'd0;
            snd_reg     <= 8'd0;
            hires_reg   <= 1'b0;
            exit_reg    <= 1'b0;
            cnt_reg     <= 7'd0;
            hit_reg     <= 1'b0;
            rd_reg      <= 8'd0;
            draw_reg    <= 1'b0;
            wait_reg    <= 1'b0;
            fault_reg   <= c8x_pkg::FAULT_NONE;
            vvalid_reg  <= 16'd0;
            vrvalid_reg <= 1'b0;
            clr_op_reg  <= 1'b0;
            for (int f = 0; f < c8x_pkg::FLAG_SLOTS; f++)
            begin
                flag_reg[f] <= 8'd0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            i_reg       <= i_next;
            lvl_reg     <= lvl_next;
            dt_reg      <= dt_next;
            snd_reg     <= snd_next;
            hires_reg   <= hires_next;
            exit_reg    <= exit_next;
            cnt_reg     <= cnt_next;
            hit_reg     <= hit_next;
            rd_reg      <= rd_next;
            draw_reg    <= draw_next;
            wait_reg    <= wait_next;
            fault_reg   <= fault_next;
            vvalid_reg  <= vvalid_next;
            vrvalid_reg <= vvalid_reg[v_raddr];
            clr_op_reg  <= clr_op_next;
            if (flag_we)
            begin
                flag_reg[cnt_reg[c8x_pkg::FLAG_AW-1:0]] <= v_data;
            end
        end
    end

endmodule

>>> sv/chip8_instruction_execute_core.sv
`timescale 1ns / 1ps
// The single execution sequencer with its single-read-port register file sets the rate.
// Throughput: one request at a time in the sequencer; a 2-deep queue in front and one
// result register behind. Reset: async, active low; a screen clearing pass over every row
// follows, during which full is high.
module chip8_instruction_execute_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  c8x_pkg::cmd_t              cmd,
    output logic                       empty,
    input  logic                       pop,
    output c8x_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_idx,
    input  logic [c8x_pkg::CFG_W-1:0]  cfg_data
);

    c8x_pkg::cfg_t    cfg_reg;
    c8x_pkg::qent_t   head;
    logic             head_valid, head_pop;
    c8x_pkg::rsp_t    res, rsp_reg;
    c8x_pkg::status_t st;
    logic             out_valid_reg, out_valid_next;

    c8x_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .hold(st.clearing), .head(head), .head_valid(head_valid), .head_pop(head_pop)
    );

    c8x_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .head(head), .head_valid(head_valid),
        .head_pop(head_pop), .out_free(!out_valid_reg), .res(res), .st(st)
    );

    assign empty = !out_valid_reg;
    assign rsp   = rsp_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (st.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st.res_load)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg           <= 1'b0;
            cfg_reg.quirk_mode      <= 1'b0;
            cfg_reg.small_font_base <= c8x_pkg::SMALL_FONT_RESET;
            cfg_reg.large_font_base <= c8x_pkg::LARGE_FONT_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    c8x_pkg::CFG_QUIRK:      cfg_reg.quirk_mode      <= cfg_data[0];
                    c8x_pkg::CFG_SMALL_FONT: cfg_reg.small_font_base <= cfg_data;
                    c8x_pkg::CFG_LARGE_FONT: cfg_reg.large_font_base <= cfg_data;
                    default:                 cfg_reg.quirk_mode      <= cfg_reg.quirk_mode;
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        st.clearing |-> full) else $error("request accepted during screen clearing");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        st.res_load |-> !out_valid_reg) else $error("result register overwritten");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        st.res_load |=> !empty) else $error("loaded result not presented");
`endif

endmodule

>>> test/chip8_instruction_execute_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for chip8_instruction_execute_core: a built-in CHIP-8/SUPER-CHIP
// predictor checks every result in order. Depends on c8x_pkg and the core only.
module chip8_instruction_execute_core_tb;
    import c8x_pkg::*;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    cmd_t cmd;
    logic empty;
    logic pop;
    rsp_t rsp;
    logic cfg_we;
    logic [1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    chip8_instruction_execute_core uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .empty(empty), .pop(pop), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // predicted machine state
    logic [7:0]  vreg [16];
    logic [15:0] ireg;
    logic [11:0] pcr;
    logic [11:0] call_stack [16];
    int          stack_lvl;
    logic [7:0]  ram [MEM_DEPTH];
    bit          ram_valid [MEM_DEPTH];
    bit          pixels [SCR_W*SCR_H];
    logic [7:0]  delay_tmr;
    logic [7:0]  sound_tmr;
    logic [7:0]  saved_flags [FLAG_SLOTS];
    bit          hires;
    bit          exit_seen;
    bit          schip_mode;
    logic [11:0] small_font;
    logic [11:0] large_font;

    cmd_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   errors;
    int   reqs_issued;
    int   rsps_checked;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic rsp_t predict_core(cmd_t c);
        rsp_t        r;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy, hit, bits;
        logic [11:0] nnn;
        logic [15:0] op;
        int          s, w, h, cx, cy, rows, j, i, p, k;
        r = '0;
        op = c.opcode;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        kk = op[7:0];
        nnn = op[11:0];
        case (c.item_kind)
            KIND_WRMEM:
            begin
                ram[c.access_address % MEM_DEPTH] = c.write_byte;
                ram_valid[c.access_address % MEM_DEPTH] = 1'b1;
            end
            KIND_RDMEM: r.read_data = ram[c.access_address % MEM_DEPTH];
            KIND_RDPIX: r.read_data = {7'd0, pixels[c.access_address]};
            default:
            begin
                pcr = pcr + 12'd2;
                vx = vreg[x];
                vy = vreg[y];
                case (op[15:12])
                    4'h0:
                    begin
                        if (op[15:4] == 12'h00C)
                        begin
                            for (p = SCR_W*SCR_H - 1; p >= 0; p--)
                                pixels[p] = (p >= n*SCR_W) ? pixels[p - n*SCR_W] : 1'b0;
                        end
                        else if (op == 16'h00E0)
                        begin
                            foreach (pixels[p]) pixels[p] = 1'b0;
                            r.draw_requested = 1'b1;
                        end
                        else if (op == 16'h00EE)
                        begin
                            if (stack_lvl == 0)
                                r.fault_code = FAULT_UNDERFLOW;
                            else
                            begin
                                stack_lvl--;
                                pcr = call_stack[stack_lvl];
                            end
                        end
                        else if (op == 16'h00FB)
                        begin
                            for (s = 0; s < SCR_H; s++)
                                for (i = SCR_W - 1; i >= 0; i--)
                                    pixels[s*SCR_W + i] = (i >= 4) ? pixels[s*SCR_W + i - 4] : 1'b0;
                        end
                        else if (op == 16'h00FC)
                        begin
                            for (s = 0; s < SCR_H; s++)
                                for (i = 0; i < SCR_W; i++)
                                    pixels[s*SCR_W + i] =
                                        (i < SCR_W - 4) ? pixels[s*SCR_W + i + 4] : 1'b0;
                        end
                        else if (op == 16'h00FD) exit_seen = 1'b1;
                        else if (op == 16'h00FE) hires = 1'b0;
                        else if (op == 16'h00FF) hires = 1'b1;
                    end
                    4'h1: pcr = nnn;
                    4'h2:
                    begin
                        if (stack_lvl >= 16)
                            r.fault_code = FAULT_OVERFLOW;
                        else
                        begin
                            call_stack[stack_lvl] = pcr;
                            stack_lvl++;
                            pcr = nnn;
                        end
                    end
                    4'h3: if (vx == kk) pcr = pcr + 12'd2;
                    4'h4: if (vx != kk) pcr = pcr + 12'd2;
                    4'h5: if (n == 0 && vx == vy) pcr = pcr + 12'd2;
                    4'h6: vreg[x] = kk;
                    4'h7: vreg[x] = vx + kk;
                    4'h8:
                    begin
                        case (n)
                            4'h0: vreg[x] = vy;
                            4'h1: vreg[x] = vx | vy;
                            4'h2: vreg[x] = vx & vy;
                            4'h3: vreg[x] = vx ^ vy;
                            4'h4:
                            begin
                                vreg[15] = ({1'b0, vx} + {1'b0, vy}) >> 8;
                                vreg[x] = vx + vy;
                            end
                            4'h5:
                            begin
                                vreg[15] = (vx >= vy);
                                vreg[x] = vx - vy;
                            end
                            4'h6:
                            begin
                                if (!schip_mode) vx = vy;
                                vreg[15] = vx[0];
                                vreg[x] = vx >> 1;
                            end
                            4'h7:
                            begin
                                vreg[15] = (vy >= vx);
                                vreg[x] = vy - vx;
                            end
                            4'hE:
                            begin
                                if (!schip_mode) vx = vy;
                                vreg[15] = vx[7];
                                vreg[x] = vx << 1;
                            end
                            default: ;
                        endcase
                    end
                    4'h9: if (n == 0 && vx != vy) pcr = pcr + 12'd2;
                    4'hA: ireg = nnn;
                    4'hB: pcr = nnn + (schip_mode ? vx : vreg[0]);
                    4'hC: vreg[x] = c.random_byte & kk;
                    4'hD:
                    begin
                        w = hires ? SCR_W : SCR_W / 2;
                        h = hires ? SCR_H : SCR_H / 2;
                        cx = vx % w;
                        cy = vy % h;
                        rows = (n != 0) ? n : 16;
                        hit = 0;
                        for (j = 0; j < rows && cy + j < h; j++)
                        begin
                            bits = ram[(ireg + j) % MEM_DEPTH];
                            for (i = 0; i < 8 && cx + i < w; i++)
                            begin
                                p = (cx + i) + (cy + j) * w;
                                if (bits[7 - i])
                                begin
                                    if (pixels[p]) hit = 1;
                                    pixels[p] = !pixels[p];
                                end
                            end
                        end
                        vreg[15] = hit;
                        r.draw_requested = 1'b1;
                    end
                    4'hE:
                    begin
                        if ((kk == 8'h9E && c.keys_down[vx[3:0]]) ||
                            (kk == 8'hA1 && !c.keys_down[vx[3:0]]))
                            pcr = pcr + 12'd2;
                    end
                    default:
                    begin
                        case (kk)
                            8'h07: vreg[x] = delay_tmr;
                            8'h0A:
                            begin
                                k = 16;
                                for (i = 15; i >= 0; i--) if (c.keys_down[i]) k = i;
                                if (k == 16)
                                begin
                                    pcr = pcr - 12'd2;
                                    r.waiting_key = 1'b1;
                                end
                                else
                                    vreg[x] = k;
                            end
                            8'h15: delay_tmr = vx;
                            8'h18: sound_tmr = vx;
                            8'h1E: ireg = ireg + vx;
                            8'h29: ireg = small_font + vx[3:0] * 5;
                            8'h30:
                            begin
                                if (vx > 9) r.fault_code = FAULT_DIGIT;
                                else ireg = large_font + vx * 10;
                            end
                            8'h33:
                            begin
                                ram[ireg % MEM_DEPTH] = vx / 100;
                                ram[(ireg + 1) % MEM_DEPTH] = (vx / 10) % 10;
                                ram[(ireg + 2) % MEM_DEPTH] = vx % 10;
                                for (i = 0; i < 3; i++) ram_valid[(ireg + i) % MEM_DEPTH] = 1'b1;
                            end
                            8'h55:
                            begin
                                for (i = 0; i <= x; i++)
                                begin
                                    ram[(ireg + i) % MEM_DEPTH] = vreg[i];
                                    ram_valid[(ireg + i) % MEM_DEPTH] = 1'b1;
                                end
                                if (!schip_mode) ireg = ireg + x + 1;
                            end
                            8'h65:
                            begin
                                for (i = 0; i <= x; i++) vreg[i] = ram[(ireg + i) % MEM_DEPTH];
                                if (!schip_mode) ireg = ireg + x + 1;
                            end
                            8'h75: for (i = 0; i <= x && i < FLAG_SLOTS; i++) saved_flags[i] = vreg[i];
                            8'h85: for (i = 0; i <= x && i < FLAG_SLOTS; i++) vreg[i] = saved_flags[i];
                            default: ;
                        endcase
                    end
                endcase
            end
        endcase
        r.next_pc = pcr;
        r.index_value = ireg;
        r.exit_requested = exit_seen;
        r.high_res = hires;
        r.delay_value = delay_tmr;
        r.sound_value = sound_tmr;
        return r;
    endfunction

    task automatic issue(input logic [1:0] kind, input logic [15:0] op, input logic [15:0] keys,
                         input logic [12:0] addr, input logic [7:0] wb);
        cmd_t c;
        c.item_kind = kind;
        c.opcode = op;
        c.random_byte = $urandom_range(255);
        c.keys_down = keys;
        c.access_address = addr;
        c.write_byte = wb;
        expected_rsps.push_back(predict_core(c));
        pending_reqs.push_back(c);
        reqs_issued++;
    endtask

    // never let a read touch memory that has not been written
    task automatic cover_ram(input int base, input int count);
        int a;
        for (int i = 0; i < count; i++)
        begin
            a = (base + i) % MEM_DEPTH;
            if (!ram_valid[a])
                issue(KIND_WRMEM, $urandom, $urandom, a + MEM_DEPTH * $urandom_range(1),
                      $urandom_range(255));
        end
    endtask

    task automatic exec_op(input logic [15:0] op, input logic [15:0] keys);
        if (op[15:12] == 4'hD)
            cover_ram(ireg, (op[3:0] != 0) ? op[3:0] : 16);
        else if (op[15:12] == 4'hF && op[7:0] == 8'h65)
            cover_ram(ireg, op[11:8] + 1);
        issue(KIND_EXEC, op, keys, $urandom, $urandom);
    endtask

    function automatic logic [15:0] random_opcode();
        logic [15:0] op;
        logic [7:0]  f_codes [12] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                                      8'h30, 8'h33, 8'h55, 8'h65, 8'h75, 8'h85};
        logic [15:0] sys_ops [8] = '{16'h00E0, 16'h00EE, 16'h00FB, 16'h00FC,
                                     16'h00FD, 16'h00FE, 16'h00FF, 16'h00C0};
        op = $urandom;
        case (op[15:12])
            4'h0:
            begin
                if ($urandom_range(9) != 0) op = sys_ops[$urandom_range(7)] | $urandom_range(15);
                if (op[15:4] != 12'h00C && op[3:0] > 4'hF) op = op;
            end
            4'h8: if ($urandom_range(7) != 0) op[3:0] = $urandom_range(7) == 0 ? 4'hE : $urandom_range(7);
            4'hE: if ($urandom_range(7) != 0) op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
            4'hF: if ($urandom_range(9) != 0) op[7:0] = f_codes[$urandom_range(11)];
            default: ;
        endcase
        // keep 00E0 and 00EE exact; the other sys ops keep their ORed-in low nibble
        if (op[15:8] == 8'h00 && op[7:4] == 4'hE) op[3:0] = $urandom_range(1) ? 4'h0 : 4'hE;
        return op;
    endfunction

    task automatic random_item();
        int pick;
        logic [15:0] keys;
        logic [12:0] a;
        pick = $urandom_range(99);
        keys = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
        if (pick < 75)
            exec_op(random_opcode(), keys);
        else if (pick < 85)
            issue(KIND_WRMEM, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 92)
        begin
            a = $urandom;
            cover_ram(a, 1);
            issue(KIND_RDMEM, $urandom, $urandom, a, $urandom);
        end
        else
            issue(KIND_RDPIX, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        while (expected_rsps.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [11:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_QUIRK:      schip_mode = val[0];
            CFG_SMALL_FONT: small_font = val;
            default:        large_font = val;
        endcase
    endtask

    // request side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                void'(pending_reqs.pop_front());
            if (!push || !full)
            begin
                if (pending_reqs.size() > (push && !full ? 1 : 0) - (push && !full ? 1 : 0) &&
                    pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    cmd <= pending_reqs[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result side
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result, next_pc %0d", rsp.next_pc);
                    errors++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    check_field("next_pc", e.next_pc, rsp.next_pc);
                    check_field("index_value", e.index_value, rsp.index_value);
                    check_field("read_data", e.read_data, rsp.read_data);
                    check_field("draw_requested", e.draw_requested, rsp.draw_requested);
                    check_field("exit_requested", e.exit_requested, rsp.exit_requested);
                    check_field("high_res", e.high_res, rsp.high_res);
                    check_field("waiting_key", e.waiting_key, rsp.waiting_key);
                    check_field("fault_code", e.fault_code, rsp.fault_code);
                    check_field("delay_value", e.delay_value, rsp.delay_value);
                    check_field("sound_value", e.sound_value, rsp.sound_value);
                    rsps_checked++;
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #30ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_idx = CFG_QUIRK;
        cfg_data = '0;
        errors = 0;
        reqs_issued = 0;
        rsps_checked = 0;
        send_idle_pct = 35;
        recv_idle_pct = 80;
        foreach (vreg[i]) vreg[i] = 0;
        foreach (ram_valid[i]) ram_valid[i] = 0;
        foreach (ram[i]) ram[i] = 0;
        foreach (pixels[i]) pixels[i] = 0;
        foreach (saved_flags[i]) saved_flags[i] = 0;
        ireg = 0;
        pcr = PC_RESET;
        stack_lvl = 0;
        delay_tmr = 0;
        sound_tmr = 0;
        hires = 0;
        exit_seen = 0;
        schip_mode = 0;
        small_font = SMALL_FONT_RESET;
        large_font = LARGE_FONT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: clipping at edges, scrolls, flags, faults, key wait, stack limits
        exec_op(16'hA300, 16'h0);
        for (int i = 0; i < 16; i++) issue(KIND_WRMEM, 16'h0, 16'h0, 13'h300 + i, 8'hFF - i);
        exec_op(16'h00FF, 16'h0);
        exec_op(16'h607C, 16'h0);
        exec_op(16'h613C, 16'h0);
        exec_op(16'hD010, 16'h0);
        exec_op(16'hD01F, 16'h0);
        exec_op(16'h00C5, 16'h0);
        exec_op(16'h00FB, 16'h0);
        exec_op(16'h00FC, 16'h0);
        issue(KIND_RDPIX, 16'h0, 16'h0, 13'h1FFF, 8'h0);
        exec_op(16'h00FE, 16'h0);
        exec_op(16'hD01F, 16'h0);
        exec_op(16'h00E0, 16'h0);
        exec_op(16'h62FF, 16'h0);
        exec_op(16'h8F24, 16'h0);
        exec_op(16'h8F25, 16'h0);
        exec_op(16'h823E, 16'h0);
        exec_op(16'h8236, 16'h0);
        exec_op(16'h8237, 16'h0);
        exec_op(16'h6A0A, 16'h0);
        exec_op(16'hFA30, 16'h0);
        exec_op(16'hF30A, 16'h0);
        exec_op(16'hF30A, 16'h8000);
        exec_op(16'h00EE, 16'h0);
        for (int i = 0; i < 17; i++) exec_op(16'h2FFE, 16'h0);
        for (int i = 0; i < 16; i++) exec_op(16'h00EE, 16'h0);
        exec_op(16'hFF55, 16'h0);
        exec_op(16'hFF75, 16'h0);
        exec_op(16'hFF85, 16'h0);
        exec_op(16'hF233, 16'h0);
        exec_op(16'hFF65, 16'h0);
        exec_op(16'hC0FF, 16'hFFFF);
        exec_op(16'hE09E, 16'hFFFF);
        exec_op(16'hE0A1, 16'h0);
        exec_op(16'hBFFF, 16'h0);
        exec_op(16'hF015, 16'h0);
        exec_op(16'hF118, 16'h0);
        exec_op(16'hF207, 16'h0);
        exec_op(16'h00FD, 16'h0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_cfg(CFG_QUIRK, 12'd1);
                    write_cfg(CFG_SMALL_FONT, 12'd0);
                    write_cfg(CFG_LARGE_FONT, 12'hFFF);
                end
                1:
                begin
                    write_cfg(CFG_QUIRK, 12'd0);
                    write_cfg(CFG_SMALL_FONT, 12'hFFF);
                    write_cfg(CFG_LARGE_FONT, 12'd0);
                end
                2:
                begin
                    send_idle_pct = 80;
                    recv_idle_pct = 35;
                    write_cfg(CFG_QUIRK, 12'd1);
                    write_cfg(CFG_SMALL_FONT, $urandom);
                end
                3: write_cfg(CFG_LARGE_FONT, $urandom);
                4:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_cfg(CFG_QUIRK, 12'd0);
                    write_cfg(CFG_SMALL_FONT, SMALL_FONT_RESET);
                end
                default: write_cfg(CFG_LARGE_FONT, LARGE_FONT_RESET);
            endcase
            for (int i = 0; i < 275; i++) random_item();
            wait_idle();
        end

        $display("Run covered %0d requests over 7 config phases; %0d results checked.",
                 reqs_issued, rsps_checked);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
